### design/pfts_pkg.sv
// pfts_pkg: shared types and constants of the pwm timer settings unit
// used by pfts_div and pwm_frequency_to_timer_settings_unit; no dependencies
package pfts_pkg;

	// width of the shared serial divider
	localparam int DIV_W = 30;
	localparam int NUM_CHANNELS_DEF = 4;

	localparam logic [DIV_W-1:0] BASE_CLOCK = 30'd640000000;
	localparam logic [31:0] FREQ_MAX = 32'd320000000;
	localparam logic [15:0] DUTY_MAX = 16'd10000;
	localparam logic [13:0] DUTY_FULL = 14'd10000;
	localparam logic [13:0] DUTY_HALF = 14'd5000;
	localparam logic [DIV_W-1:0] PERIOD_LIMIT = 30'h10000;
	localparam logic [3:0] PRE_LAST = 4'd15;

	typedef enum logic [1:0] {
		ACT_STOP   = 2'd0,
		ACT_NONE   = 2'd1,
		ACT_START  = 2'd2,
		ACT_UPDATE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_PER,
		ST_SCALE,
		ST_MUL,
		ST_DIV_CMP,
		ST_DONE
	} state_t;

endpackage

### design/pfts_div.sv
// pfts_div: bit-serial restoring divider, one quotient bit per cycle
// depends on pfts_pkg for the datapath width; divisor must stay below 2^(DIV_W-1)
module pfts_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pfts_pkg::DIV_W-1:0] dividend,
	input  logic [pfts_pkg::DIV_W-1:0] divisor,
	output logic                     done,
	output logic [pfts_pkg::DIV_W-1:0] quotient
);

	localparam int W = pfts_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W-1:0] trial;
	logic         fits;

	assign trial = {rem_q[W-2:0], quo_q[W-1]};
	assign fits  = trial >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - dvs_q : trial;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/pwm_frequency_to_timer_settings_unit.sv
// pwm_frequency_to_timer_settings_unit: turns a frequency and duty request into
// prescaler, period and compare values; uses pfts_pkg and pfts_div
// sequence: a stop or ignored request goes from idle straight to done; a start or update
//   runs a serial divide for the period, up to 14 prescaler shifts,
//   up to 14 shift-add multiply steps, then a second serial divide for rounding
// one request at a time: a new request is not taken until the unit is through with the last one;
//   the next one is taken once the last result has moved to the output register
// reset: asynchronous, clears the per-channel running flags, fsm and output valid
module pwm_frequency_to_timer_settings_unit #(
	parameter int NUM_CHANNELS = pfts_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // freq_hz[31:0], duty[47:32]
	input  logic [1:0]  s_tuser,  // chan[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // prescale[3:0], period_count[19:4], compare_count[35:20], zero
	output logic [1:0]  m_tuser   // action[1:0]
);

	localparam int W = pfts_pkg::DIV_W;

	pfts_pkg::state_t state_q, state_nxt;

	logic [NUM_CHANNELS-1:0] running_q;
	logic [W-1:0]  q_q;
	logic [3:0]    pre_q;
	logic [15:0]   per_q;
	logic [15:0]   cmp_q;
	logic [W-1:0]  mcand_q;
	logic [13:0]   mplier_q;
	logic [W-1:0]  acc_q;
	logic [13:0]   sub_q;
	pfts_pkg::action_t act_q;

	logic          m_tvalid_q;
	logic [3:0]    pre_out_q;
	logic [15:0]   per_out_q;
	logic [15:0]   cmp_out_q;
	pfts_pkg::action_t act_out_q;

	logic [31:0]   f_in;
	logic [15:0]   d_in;
	logic [28:0]   f_cl;
	logic [13:0]   d_cl;
	logic          chan_ok;
	logic          chan_run;
	logic          accept;
	logic          go;
	logic          div_start;
	logic          out_load;
	logic [W-1:0]  div_dividend;
	logic [W-1:0]  div_divisor;
	logic          div_done;
	logic [W-1:0]  div_quo;
	logic          scale_more;

	assign f_in = s_tdata[31:0];
	assign d_in = s_tdata[47:32];
	assign f_cl = (f_in > pfts_pkg::FREQ_MAX) ? pfts_pkg::FREQ_MAX[28:0] : f_in[28:0];
	assign d_cl = (d_in > pfts_pkg::DUTY_MAX) ? pfts_pkg::DUTY_FULL : d_in[13:0];

	always_comb begin
		chan_run = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (32'(s_tuser) == i)
				chan_run = running_q[i];
		end
	end

	assign chan_ok    = 32'(s_tuser) < NUM_CHANNELS;
	assign accept     = s_tvalid && s_tready;
	assign go         = chan_ok && (f_in != 32'd0);
	assign scale_more = (q_q > pfts_pkg::PERIOD_LIMIT) && (pre_q < pfts_pkg::PRE_LAST);

	// output decode
	always_comb begin
		s_tready  = (state_q == pfts_pkg::ST_IDLE);
		div_start = ((state_q == pfts_pkg::ST_IDLE) && s_tvalid && go)
			|| ((state_q == pfts_pkg::ST_MUL) && (mplier_q == 14'd0));
		out_load  = (state_q == pfts_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
		if (state_q == pfts_pkg::ST_IDLE) begin
			div_dividend = pfts_pkg::BASE_CLOCK;
			div_divisor  = W'(f_cl);
		end else begin
			div_dividend = acc_q;
			div_divisor  = W'(pfts_pkg::DUTY_FULL);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pfts_pkg::ST_IDLE: begin
				if (accept)
					state_nxt = go ? pfts_pkg::ST_DIV_PER : pfts_pkg::ST_DONE;
			end
			pfts_pkg::ST_DIV_PER: begin
				if (div_done)
					state_nxt = pfts_pkg::ST_SCALE;
			end
			pfts_pkg::ST_SCALE: begin
				if (!scale_more)
					state_nxt = pfts_pkg::ST_MUL;
			end
			pfts_pkg::ST_MUL: begin
				if (mplier_q == 14'd0)
					state_nxt = pfts_pkg::ST_DIV_CMP;
			end
			pfts_pkg::ST_DIV_CMP: begin
				if (div_done)
					state_nxt = pfts_pkg::ST_DONE;
			end
			pfts_pkg::ST_DONE: begin
				if (out_load)
					state_nxt = pfts_pkg::ST_IDLE;
			end
			default: state_nxt = pfts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfts_pkg::ST_IDLE;
			running_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept && chan_ok) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (32'(s_tuser) == i)
						running_q[i] <= (f_in != 32'd0);
				end
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			pfts_pkg::ST_IDLE: begin
				pre_q <= 4'd0;
				per_q <= 16'd0;
				cmp_q <= 16'd0;
				sub_q <= pfts_pkg::DUTY_FULL - d_cl;
				if (!chan_ok)
					act_q <= pfts_pkg::ACT_NONE;
				else if (f_in == 32'd0)
					act_q <= chan_run ? pfts_pkg::ACT_STOP : pfts_pkg::ACT_NONE;
				else
					act_q <= chan_run ? pfts_pkg::ACT_UPDATE : pfts_pkg::ACT_START;
			end
			pfts_pkg::ST_DIV_PER: begin
				if (div_done)
					q_q <= div_quo;
			end
			pfts_pkg::ST_SCALE: begin
				if (scale_more) begin
					q_q   <= {1'b0, q_q[W-1:1]};
					pre_q <= pre_q + 4'd1;
				end else begin
					per_q    <= q_q[15:0] - 16'd1;
					mcand_q  <= W'(q_q[15:0] - 16'd1);
					mplier_q <= sub_q;
					acc_q    <= W'(pfts_pkg::DUTY_HALF);
				end
			end
			pfts_pkg::ST_MUL: begin
				if (mplier_q != 14'd0) begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q  <= {mcand_q[W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[13:1]};
				end
			end
			pfts_pkg::ST_DIV_CMP: begin
				if (div_done)
					cmp_q <= div_quo[15:0];
			end
			pfts_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			act_out_q <= act_q;
			pre_out_q <= pre_q;
			per_out_q <= per_q;
			cmp_out_q <= cmp_q;
		end
	end

	pfts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = act_out_q;
	assign m_tdata  = {4'd0, cmp_out_q, per_out_q, pre_out_q};

	// stop and no-op results carry no timer settings
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pfts_pkg::ACT_STOP || m_tuser == pfts_pkg::ACT_NONE)
		|-> m_tdata == 40'd0)
		else $error("stop or no-op result with nonzero settings");

	a_pre_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd14)
		else $error("prescale out of range");

	a_run_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == pfts_pkg::ACT_START || m_tuser == pfts_pkg::ACT_UPDATE)
		|-> m_tdata[19:4] != 16'd0)
		else $error("running result with zero period");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == pfts_pkg::ST_DIV_PER || state_q == pfts_pkg::ST_DIV_CMP)
		else $error("divider finished outside a divide state");

endmodule
